FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the wheel speed mixer checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disable.
`define MWSM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A stalled channel keeps valid high and its payload stable.
`define MWSM_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
	`MWSM_ASSERT(lbl, clk, rst_n, (vld && !rdy) |=> (vld && $stable(sig)), "stalled item changed")

`endif

FILE: rtl/mwsm_pkg.sv
// ---------------------------------------------------------------------------
// mwsm_pkg
// Types and constants of the mecanum wheel speed mixer.
// ---------------------------------------------------------------------------
`default_nettype none

package mwsm_pkg;

	localparam int LIMIT_W    = 15;
	localparam int QUOT_W     = LIMIT_W;   // scaled magnitude never exceeds the wheel limit
	localparam int NUM_WHEELS = 4;

	typedef logic [LIMIT_W-1:0] limit_t;

	localparam limit_t LIMIT_RESET       = 15'h7FFF;
	localparam limit_t WHEEL_LIMIT_RESET = 15'd3500;

	typedef enum logic [1:0] {
		REG_LIMIT_FORWARD  = 2'd0,
		REG_LIMIT_SIDEWAYS = 2'd1,
		REG_LIMIT_ROTATION = 2'd2,
		REG_WHEEL_LIMIT    = 2'd3
	} cfg_reg_t;

endpackage

`default_nettype wire

FILE: rtl/mecanum_wheel_speed_mixer_core.sv
// ---------------------------------------------------------------------------
// mecanum_wheel_speed_mixer_core
// Clamps a chassis velocity command per axis, mixes it into four mecanum
// wheel speeds and scales all four by limit/max when the largest wheel
// magnitude exceeds the wheel limit (exact, truncated toward zero).
// ---------------------------------------------------------------------------
//  channel   | direction | handshake                | payload
//  ----------+-----------+--------------------------+---------------------------
//  s_axis    | in        | s_axis_tvalid/tready     | vel_forward, vel_sideways,
//            |           |                          | vel_rotation
//  m_axis    | out       | m_axis_tvalid/tready     | wheel_speed_0 .. _3
//  cfg       | in        | cfg_valid/cfg_ready      | cfg_index, cfg_data
//
//  Pipeline: clamp, mix, magnitude/max, multiply, 15 divider
//  stages (one quotient bit each) and the output register.
//  One item per cycle sustained while m_axis is ready; each stage has its
//  own valid bit, and a stage loads when it is empty or its successor
//  loads, so bubbles close up. A stall at m_axis holds the output
//  register; items behind it keep advancing into empty stages and input
//  is taken until the pipe is full. arst_n clears all valid bits and
//  sets the limits to their reset values. cfg_ready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module mecanum_wheel_speed_mixer_core #(
	parameter int SPEED_WIDTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	// s_axis: vel_forward, vel_sideways, vel_rotation (low to high), zero pad
	input  wire logic                                      s_axis_tvalid,
	output logic                                           s_axis_tready,
	input  wire logic [((3*SPEED_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
	// m_axis: wheel_speed_0, _1, _2, _3 (low to high), zero pad
	output logic                                           m_axis_tvalid,
	input  wire logic                                      m_axis_tready,
	output logic [((4*SPEED_WIDTH+7)/8)*8-1:0]             m_axis_tdata,
	// configuration write channel
	input  wire logic                                      cfg_valid,
	output logic                                           cfg_ready,
	input  wire mwsm_pkg::cfg_reg_t                        cfg_index,
	input  wire mwsm_pkg::limit_t                          cfg_data
);

	import mwsm_pkg::*;

	localparam int SW          = SPEED_WIDTH;
	// compare width: holds a signed SW-bit value and the unsigned 15-bit limit
	localparam int CMP_W       = ((SW > LIMIT_W) ? SW : LIMIT_W) + 2;
	localparam int MIX_W       = SW + 2;       // sum of three clamped axes
	localparam int MAG_W       = SW + 1;       // magnitude of a mixed speed
	localparam int PROD_W      = MAG_W + LIMIT_W;

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	limit_t lim_fwd_q, lim_side_q, lim_rot_q, wheel_lim_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_fwd_q   <= LIMIT_RESET;
			lim_side_q  <= LIMIT_RESET;
			lim_rot_q   <= LIMIT_RESET;
			wheel_lim_q <= WHEEL_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LIMIT_FORWARD:  lim_fwd_q   <= cfg_data;
				REG_LIMIT_SIDEWAYS: lim_side_q  <= cfg_data;
				REG_LIMIT_ROTATION: lim_rot_q   <= cfg_data;
				REG_WHEEL_LIMIT:    wheel_lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// symmetric clamp of one axis to [-lim, +lim]
	function automatic logic signed [SW-1:0] clamp_axis(input logic signed [SW-1:0] v,
			input limit_t lim);
		logic signed [CMP_W-1:0] vx;
		logic signed [CMP_W-1:0] lx;
		logic signed [CMP_W-1:0] rx;
		begin
			vx = CMP_W'(v);
			lx = $signed({{(CMP_W-LIMIT_W){1'b0}}, lim});
			if (vx > lx)
				rx = lx;
			else if (vx < -lx)
				rx = -lx;
			else
				rx = vx;
			clamp_axis = rx[SW-1:0];
		end
	endfunction

	// ---------------------------------------------------------------------
	// Stage enables: a stage loads when empty or when its successor loads
	// ---------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic dv_vld_s [QUOT_W];
	logic dv_en    [QUOT_W];

	assign en_s5 = !v_s5 || m_axis_tready;
	assign en_s4 = !v_s4 || dv_en[0];
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_axis_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= dv_vld_s[QUOT_W-1];
		end
	end

	// ---------------------------------------------------------------------
	// Stage 1: per-axis clamp
	// ---------------------------------------------------------------------
	logic signed [SW-1:0] fwd_s1, side_s1, rot_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			fwd_s1  <= clamp_axis(s_axis_tdata[0*SW +: SW], lim_fwd_q);
			side_s1 <= clamp_axis(s_axis_tdata[1*SW +: SW], lim_side_q);
			rot_s1  <= clamp_axis(s_axis_tdata[2*SW +: SW], lim_rot_q);
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: wheel mix
	// ---------------------------------------------------------------------
	logic signed [MIX_W-1:0] mix_s2 [NUM_WHEELS];
	logic signed [MIX_W-1:0] fx, sx, rx;

	always_comb begin
		fx = MIX_W'(fwd_s1);
		sx = MIX_W'(side_s1);
		rx = MIX_W'(rot_s1);
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			mix_s2[0] <=  fx - sx + rx;
			mix_s2[1] <=  fx + sx + rx;
			mix_s2[2] <= -fx + sx + rx;
			mix_s2[3] <= -fx - sx + rx;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: magnitudes, largest magnitude, scale decision
	// ---------------------------------------------------------------------
	logic [MAG_W-1:0] mag_c [NUM_WHEELS];
	logic             neg_c [NUM_WHEELS];
	logic [MAG_W-1:0] max01_c, max23_c, max_c;

	logic [MAG_W-1:0] mag_s3 [NUM_WHEELS];
	logic             neg_s3 [NUM_WHEELS];
	logic [MAG_W-1:0] max_s3;
	logic             scale_s3;

	always_comb begin
		for (int i = 0; i < NUM_WHEELS; i++) begin
			neg_c[i] = mix_s2[i][MIX_W-1];
			mag_c[i] = neg_c[i] ? MAG_W'(-mix_s2[i]) : MAG_W'(mix_s2[i]);
		end
		max01_c = (mag_c[1] > mag_c[0]) ? mag_c[1] : mag_c[0];
		max23_c = (mag_c[3] > mag_c[2]) ? mag_c[3] : mag_c[2];
		max_c   = (max23_c > max01_c) ? max23_c : max01_c;
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			mag_s3   <= mag_c;
			neg_s3   <= neg_c;
			max_s3   <= max_c;
			scale_s3 <= PROD_W'(max_c) > PROD_W'(wheel_lim_q);
		end
	end

	// ---------------------------------------------------------------------
	// Stage 4: dividend |speed| * wheel_limit
	// ---------------------------------------------------------------------
	logic [PROD_W-1:0] prod_s4 [NUM_WHEELS];
	logic [MAG_W-1:0]  mag_s4  [NUM_WHEELS];
	logic              neg_s4  [NUM_WHEELS];
	logic [MAG_W-1:0]  max_s4;
	logic              scale_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				prod_s4[i] <= {{LIMIT_W{1'b0}}, mag_s3[i]} * {{MAG_W{1'b0}}, wheel_lim_q};
			end
			mag_s4   <= mag_s3;
			neg_s4   <= neg_s3;
			max_s4   <= max_s3;
			scale_s4 <= scale_s3;
		end
	end

	// ---------------------------------------------------------------------
	// Divider: restoring division, one quotient bit per stage, MSB first.
	// When scaling, dividend < max * 2^QUOT_W, so QUOT_W bits suffice.
	// ---------------------------------------------------------------------
	logic [PROD_W-1:0] dv_rem_s   [QUOT_W][NUM_WHEELS];
	logic [QUOT_W-1:0] dv_quo_s   [QUOT_W][NUM_WHEELS];
	logic [MAG_W-1:0]  dv_mag_s   [QUOT_W][NUM_WHEELS];
	logic              dv_neg_s   [QUOT_W][NUM_WHEELS];
	logic [MAG_W-1:0]  dv_max_s   [QUOT_W];
	logic              dv_scale_s [QUOT_W];

	for (genvar j = 0; j < QUOT_W; j++) begin : g_dv
		localparam int K = QUOT_W - 1 - j;

		logic [PROD_W-1:0] rem_in   [NUM_WHEELS];
		logic [QUOT_W-1:0] quo_in   [NUM_WHEELS];
		logic [MAG_W-1:0]  mag_in   [NUM_WHEELS];
		logic              neg_in   [NUM_WHEELS];
		logic [MAG_W-1:0]  max_in;
		logic              scale_in;
		logic              vld_in;
		logic              en_next;
		logic [PROD_W-1:0] sub;
		logic [PROD_W-1:0] rem_nx   [NUM_WHEELS];
		logic [QUOT_W-1:0] quo_nx   [NUM_WHEELS];

		if (j == 0) begin : g_head
			always_comb begin
				rem_in   = prod_s4;
				quo_in   = '{default: '0};
				mag_in   = mag_s4;
				neg_in   = neg_s4;
				max_in   = max_s4;
				scale_in = scale_s4;
				vld_in   = v_s4;
			end
		end else begin : g_body
			always_comb begin
				rem_in   = dv_rem_s[j-1];
				quo_in   = dv_quo_s[j-1];
				mag_in   = dv_mag_s[j-1];
				neg_in   = dv_neg_s[j-1];
				max_in   = dv_max_s[j-1];
				scale_in = dv_scale_s[j-1];
				vld_in   = dv_vld_s[j-1];
			end
		end

		if (j == QUOT_W - 1) begin : g_tail
			assign en_next = en_s5;
		end else begin : g_mid
			assign en_next = dv_en[j+1];
		end

		assign dv_en[j] = !dv_vld_s[j] || en_next;

		always_comb begin
			sub = PROD_W'(max_in) << K;
			for (int i = 0; i < NUM_WHEELS; i++) begin
				if (rem_in[i] >= sub) begin
					rem_nx[i] = rem_in[i] - sub;
					quo_nx[i] = quo_in[i] | (QUOT_W'(1) << K);
				end else begin
					rem_nx[i] = rem_in[i];
					quo_nx[i] = quo_in[i];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_vld_s[j] <= 1'b0;
			else if (dv_en[j])
				dv_vld_s[j] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (dv_en[j]) begin
				dv_rem_s[j]   <= rem_nx;
				dv_quo_s[j]   <= quo_nx;
				dv_mag_s[j]   <= mag_in;
				dv_neg_s[j]   <= neg_in;
				dv_max_s[j]   <= max_in;
				dv_scale_s[j] <= scale_in;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stage 5: pick scaled or raw magnitude, restore sign, output register
	// ---------------------------------------------------------------------
	logic [SW-1:0]     out_c  [NUM_WHEELS];
	logic [PROD_W-1:0] sel_c  [NUM_WHEELS];
	logic [PROD_W-1:0] sgn_c  [NUM_WHEELS];
	logic [SW-1:0]     out_s5 [NUM_WHEELS];

	always_comb begin
		for (int i = 0; i < NUM_WHEELS; i++) begin
			sel_c[i] = dv_scale_s[QUOT_W-1] ? PROD_W'(dv_quo_s[QUOT_W-1][i])
			                                : PROD_W'(dv_mag_s[QUOT_W-1][i]);
			sgn_c[i] = dv_neg_s[QUOT_W-1][i] ? -sel_c[i] : sel_c[i];
			out_c[i] = sgn_c[i][SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5)
			out_s5 <= out_c;
	end

	assign m_axis_tvalid = v_s5;

	always_comb begin
		m_axis_tdata = '0;
		for (int i = 0; i < NUM_WHEELS; i++)
			m_axis_tdata[i*SW +: SW] = out_s5[i];
	end

endmodule

`default_nettype wire

FILE: rtl/mwsm_chk.sv
// ---------------------------------------------------------------------------
// mwsm_chk
// Port-level checks on the wheel speed mixer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mwsm_chk #(
	parameter int SPEED_WIDTH = 16
) (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  s_axis_tready,
	input wire logic                                  m_axis_tvalid,
	input wire logic                                  m_axis_tready,
	input wire logic [((4*SPEED_WIDTH+7)/8)*8-1:0]    m_axis_tdata
);

	import mwsm_pkg::*;

	localparam int SW = SPEED_WIDTH;
	localparam logic [SW-1:0] FIELD_MIN = {1'b1, {(SW-1){1'b0}}};

	// a result never reaches the most negative code: magnitudes stay
	// at or below the wheel limit, which fits in 15 bits
	localparam bit WIDE_FIELDS = (SW > LIMIT_W);

	logic min_hit;

	always_comb begin
		min_hit = 1'b0;
		for (int i = 0; i < NUM_WHEELS; i++)
			min_hit = min_hit | (m_axis_tdata[i*SW +: SW] == FIELD_MIN);
	end

	`MWSM_ASSERT(a_in_ready_when_out_free, clk, arst_n,
		(!m_axis_tvalid || m_axis_tready) |-> s_axis_tready,
		"input stalled while output free")
	`MWSM_ASSERT(a_no_out_after_reset, clk, arst_n,
		!$past(arst_n) |-> !m_axis_tvalid, "result right after reset")
	`MWSM_ASSERT(a_no_min_code, clk, arst_n,
		(m_axis_tvalid && WIDE_FIELDS) |-> !min_hit, "wheel speed beyond limit range")
	`MWSM_ASSERT_HOLD(a_out_hold, clk, arst_n, m_axis_tvalid, m_axis_tready, m_axis_tdata)

endmodule

bind mecanum_wheel_speed_mixer_core mwsm_chk #(
	.SPEED_WIDTH(SPEED_WIDTH)
) u_mwsm_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Stream-level test of the mecanum wheel speed mixer: velocity commands go in
// through s_axis, wheel speed sets come back on m_axis and are checked field by
// field against a predictor that clamps, mixes and scales with exact integers.
// Limits are rewritten between phases while the pipe is empty.
// ---------------------------------------------------------------------------

module tb;
	import mwsm_pkg::*;

	localparam int SPEED_W      = 16;
	localparam int S_DATA_W     = ((3*SPEED_W+7)/8)*8;
	localparam int M_DATA_W     = ((4*SPEED_W+7)/8)*8;
	localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake at all
	localparam int FLUSH_CYCLES = 40;
	localparam int MAX_SHOWN    = 10;

	typedef logic signed [SPEED_W-1:0] speed_t;
	typedef logic [M_DATA_W-1:0]       wheel_word_t;

	typedef struct {
		speed_t fwd;
		speed_t side;
		speed_t rot;
	} command_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;  // vel_forward, vel_sideways, vel_rotation
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;       // wheel_speed_0, _1, _2, _3
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	cfg_reg_t          cfg_index     = REG_LIMIT_FORWARD;
	limit_t            cfg_data      = '0;

	// predictor's copy of the limit registers
	limit_t lim_fwd   = LIMIT_RESET;
	limit_t lim_side  = LIMIT_RESET;
	limit_t lim_rot   = LIMIT_RESET;
	limit_t wheel_lim = WHEEL_LIMIT_RESET;

	command_t    commands[$];     // items waiting for the driver
	wheel_word_t speeds_due[$];   // predicted wheel sets, oldest first

	int idle_pct  = 28;   // chance in a hundred that a side idles this cycle
	bit hold_send = 1'b0; // driver offers nothing new while set
	bit s_taken   = 1'b0; // s_axis item accepted at the last rising edge
	int quiet     = 0;
	int errors    = 0;

	mecanum_wheel_speed_mixer_core #(
		.SPEED_WIDTH(SPEED_W)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------------

	function automatic longint clamp_axis(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// Clamp each axis, mix into four wheels, scale by limit/max when the
	// largest magnitude is above the wheel limit. Division truncates to zero.
	function automatic wheel_word_t mix_wheels(speed_t fwd, speed_t side, speed_t rot);
		longint      f, s, r, m, wl, a;
		longint      w [NUM_WHEELS];
		wheel_word_t word;
		f = clamp_axis(fwd, longint'(lim_fwd));
		s = clamp_axis(side, longint'(lim_side));
		r = clamp_axis(rot, longint'(lim_rot));
		w[0] =  f - s + r;
		w[1] =  f + s + r;
		w[2] = -f + s + r;
		w[3] = -f - s + r;
		m = 0;
		for (int i = 0; i < NUM_WHEELS; i++) begin
			a = (w[i] < 0) ? -w[i] : w[i];
			if (a > m)
				m = a;
		end
		wl = longint'(wheel_lim);
		word = '0;
		for (int i = 0; i < NUM_WHEELS; i++) begin
			if (m > wl)
				w[i] = (w[i] * wl) / m;
			word[i*SPEED_W +: SPEED_W] = w[i][SPEED_W-1:0];
		end
		return word;
	endfunction

	function automatic void flag_error(string msg);
		errors++;
		if (errors <= MAX_SHOWN)
			$display("%s", msg);
	endfunction

	// ---------------------------------------------------------------------
	// Driver: offers the next queued command once the current one is taken
	// ---------------------------------------------------------------------
	always @(negedge clk) begin : drive_commands
		command_t next_cmd;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_taken) begin
			if (commands.size() != 0 && !hold_send && $urandom_range(99) >= idle_pct) begin
				next_cmd = commands.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= S_DATA_W'({next_cmd.rot, next_cmd.side, next_cmd.fwd});
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver stalls at the same rate as the sender idles
	always @(negedge clk) begin
		m_axis_tready <= arst_n && ($urandom_range(99) >= idle_pct);
	end

	// ---------------------------------------------------------------------
	// Monitor: mirrors register writes, predicts on every accepted command,
	// checks every accepted wheel set, and watches for a hung pipe.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : check_wheels
		wheel_word_t want;
		bit          moved;
		if (arst_n) begin
			s_taken <= s_axis_tvalid && s_axis_tready;
			moved = 1'b0;

			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				case (cfg_index)
					REG_LIMIT_FORWARD:  lim_fwd   = cfg_data;
					REG_LIMIT_SIDEWAYS: lim_side  = cfg_data;
					REG_LIMIT_ROTATION: lim_rot   = cfg_data;
					REG_WHEEL_LIMIT:    wheel_lim = cfg_data;
					default: ;
				endcase
			end

			if (m_axis_tvalid && m_axis_tready) begin
				moved = 1'b1;
				if (speeds_due.size() == 0) begin
					flag_error($sformatf("unexpected wheel set %h", m_axis_tdata));
				end else begin
					want = speeds_due.pop_front();
					for (int i = 0; i < NUM_WHEELS; i++) begin
						if (m_axis_tdata[i*SPEED_W +: SPEED_W] !== want[i*SPEED_W +: SPEED_W])
							flag_error($sformatf("wheel_speed_%0d: expected %0d, got %0d",
								i, speed_t'(want[i*SPEED_W +: SPEED_W]),
								speed_t'(m_axis_tdata[i*SPEED_W +: SPEED_W])));
					end
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				moved = 1'b1;
				speeds_due.push_back(mix_wheels(s_axis_tdata[0 +: SPEED_W],
					s_axis_tdata[SPEED_W +: SPEED_W], s_axis_tdata[2*SPEED_W +: SPEED_W]));
			end

			if (moved) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("tb failed");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	function automatic void queue_cmd(int f, int s, int r);
		command_t c;
		c.fwd  = speed_t'(f);
		c.side = speed_t'(s);
		c.rot  = speed_t'(r);
		commands.push_back(c);
	endfunction

	// Full range, small values within +/-1200, field
	// extremes, and values right around the axis clamp.
	function automatic speed_t pick_speed(limit_t lim);
		int v;
		case ($urandom_range(5))
			0, 1: v = int'($urandom_range(65535)) - 32768;
			2: v = int'($urandom_range(2400)) - 1200;
			3: begin
				case ($urandom_range(4))
					0: v = 32767;
					1: v = -32768;
					2: v = 0;
					3: v = -1;
					default: v = 1;
				endcase
			end
			default: begin
				v = int'(lim) + int'($urandom_range(4)) - 2;
				if ($urandom_range(1))
					v = -v;
			end
		endcase
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return speed_t'(v);
	endfunction

	function automatic void queue_random(int count);
		for (int i = 0; i < count; i++)
			queue_cmd(pick_speed(lim_fwd), pick_speed(lim_side), pick_speed(lim_rot));
	endfunction

	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (commands.size() != 0 || s_axis_tvalid || speeds_due.size() != 0);
	endtask

	task automatic write_reg(cfg_reg_t idx, limit_t value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// pipe must be empty; the mirror is current after the final falling edge
	task automatic set_limits(limit_t lf, limit_t ls, limit_t lr, limit_t wl);
		write_reg(REG_LIMIT_FORWARD, lf);
		write_reg(REG_LIMIT_SIDEWAYS, ls);
		write_reg(REG_LIMIT_ROTATION, lr);
		write_reg(REG_WHEEL_LIMIT, wl);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_limits(int cap);
		set_limits(limit_t'($urandom_range(cap)), limit_t'($urandom_range(cap)),
			limit_t'($urandom_range(cap)), limit_t'($urandom_range(cap, 1)));
	endtask

	// ---------------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------------
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, reset limits (axes 32767, wheel 3500): zero command,
		// each axis alone at both extremes (negative extreme gets clamped),
		// all axes at the same extreme, a mix exactly at the wheel limit
		// and one just above it, and a few small unscaled mixes.
		queue_cmd(0, 0, 0);
		queue_cmd(32767, 0, 0);
		queue_cmd(-32768, 0, 0);
		queue_cmd(0, 32767, 0);
		queue_cmd(0, -32768, 0);
		queue_cmd(0, 0, 32767);
		queue_cmd(0, 0, -32768);
		queue_cmd(32767, 32767, 32767);
		queue_cmd(-32768, -32768, -32768);
		queue_cmd(32767, -32768, 32767);
		queue_cmd(-32768, 32767, -32768);
		queue_cmd(3500, 0, 0);
		queue_cmd(3501, 0, 0);
		queue_cmd(1166, 1167, 1167);
		queue_cmd(-1, -1, -1);
		queue_cmd(1, -1, 1);
		queue_cmd(7, -3, 5);
		queue_random(180);

		// Sender holds off mid-phase until the pipe has fully emptied.
		while (commands.size() > 90) begin
			@(posedge clk);
			#1;
		end
		hold_send = 1'b1;
		do begin
			@(posedge clk);
			#1;
		end while (s_axis_tvalid || speeds_due.size() != 0);
		hold_send = 1'b0;
		wait_drained();

		// all limits at their top: only mixes above 32767 get scaled
		set_limits(limit_t'(32767), limit_t'(32767), limit_t'(32767), limit_t'(32767));
		queue_random(200);
		wait_drained();

		// zero axis limits force every axis to zero; smallest nonzero wheel limit
		set_limits(limit_t'(0), limit_t'(0), limit_t'(0), limit_t'(1));
		queue_cmd(32767, -32768, 100);
		queue_random(60);
		wait_drained();

		// zero wheel limit: any nonzero mix collapses to zero
		set_limits(limit_t'($urandom_range(32767)), limit_t'($urandom_range(32767)),
			limit_t'($urandom_range(32767)), limit_t'(0));
		queue_cmd(0, 0, 0);
		queue_cmd(1, 0, 0);
		queue_random(60);
		wait_drained();

		// long stretch with neither side idling
		random_limits(32767);
		idle_pct = 0;
		queue_random(260);
		wait_drained();
		idle_pct = 28;

		// small limits: clamping and scaling both active most of the time
		random_limits(4000);
		queue_random(200);
		wait_drained();

		random_limits(32767);
		queue_random(170);
		wait_drained();

		repeat (FLUSH_CYCLES) @(posedge clk);
		if (speeds_due.size() != 0)
			flag_error($sformatf("%0d wheel sets never arrived", speeds_due.size()));
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
